// ===== rtl/playfair_digraph_cipher_macros.svh =====
// Assertion macros shared by the cipher RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef PLAYFAIR_DIGRAPH_CIPHER_MACROS_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked at every edge outside reset
`define PFDC_ASSERT(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (prop)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent
`define PFDC_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PFDC_ASSERT(label, clk_sig, rst_sig, prop, msg)
`define PFDC_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg)

`endif

`endif

// ===== rtl/pfdc_pkg.sv =====
`default_nettype none

package pfdc_pkg;

  // Grid geometry
  localparam int GRID_SIDE   = 5;
  localparam int GRID_CELLS  = GRID_SIDE * GRID_SIDE;
  localparam int LETTERS     = 26;
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  typedef logic [4:0] letter_t;
  typedef logic [2:0] coord_t;

  // Letter indexes, A is zero
  localparam letter_t LETTER_I = 5'd8;
  localparam letter_t LETTER_J = 5'd9;
  localparam letter_t LETTER_X = 5'd23;

  // ASCII codes
  localparam logic [7:0] CHAR_UPPER_A = 8'd65;
  localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
  localparam logic [7:0] CHAR_LOWER_A = 8'd97;
  localparam logic [7:0] CHAR_LOWER_Z = 8'd122;
  localparam logic [7:0] CASE_OFFSET  = 8'd32;
  localparam logic [6:0] OUT_BASE     = 7'd65;

  // Input commands
  localparam logic [2:0] CMD_KEY_START  = 3'd0;
  localparam logic [2:0] CMD_KEY_LETTER = 3'd1;
  localparam logic [2:0] CMD_KEY_FINISH = 3'd2;
  localparam logic [2:0] CMD_TEXT_CHAR  = 3'd3;
  localparam logic [2:0] CMD_TEXT_END   = 3'd4;

  // Work handed from front to back
  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_PLACE,
    OP_FINISH,
    OP_PAIR
  } op_kind_t;

  typedef struct packed {
    op_kind_t kind;
    letter_t  a;
    letter_t  b;
  } op_t;

  // Letter at position i of the fill alphabet (A-Z without J)
  function automatic letter_t fill_letter(input letter_t i);
    return (i >= LETTER_J) ? i + 5'd1 : i;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pfdc_queue.sv =====
`default_nettype none

`include "playfair_digraph_cipher_macros.svh"

module pfdc_queue (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  pfdc_pkg::op_t     push_op,
  output logic              full,
  input  wire logic         pop,
  output pfdc_pkg::op_t     head_op,
  output logic              empty
);
  import pfdc_pkg::*;

  op_t                    slot [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;

  assign full    = (count == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign head_op = slot[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Hold entries
  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_op;
  end

  `PFDC_ASSERT(a_no_overflow, clk, rst, push |-> (!full || pop), "queue push while full")
  `PFDC_ASSERT(a_no_underflow, clk, rst, pop |-> !empty, "queue pop while empty")
  `PFDC_ASSERT(a_count_bound, clk, rst, count <= (QUEUE_PTR_W + 1)'(QUEUE_DEPTH), "queue count past depth")

endmodule

`default_nettype wire

// ===== rtl/pfdc_front.sv =====
`default_nettype none

module pfdc_front (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       direction,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] command,
  input  wire logic [7:0] char_in,
  input  wire logic       q_full,
  output logic            push,
  output pfdc_pkg::op_t   push_op
);
  import pfdc_pkg::*;

  letter_t pending_letter, pending_letter_next;
  logic    pending_valid, pending_valid_next;
  letter_t previous_letter, previous_letter_next;
  logic    previous_valid, previous_valid_next;

  logic    accept;
  logic    key_ok;
  letter_t key_idx;
  logic    raw_upper;
  letter_t raw_idx;
  logic    doubled;

  // Fold case and J; top bit flags a letter
  function automatic logic [5:0] fold_letter(input logic [7:0] c);
    logic [7:0] u;
    letter_t    idx;
    u = c;
    if (c inside {[CHAR_LOWER_A:CHAR_LOWER_Z]}) u = c - CASE_OFFSET;
    idx = 5'(u - CHAR_UPPER_A);
    if (idx == LETTER_J) idx = LETTER_I;
    return {(u inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}), idx};
  endfunction

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign {key_ok, key_idx} = fold_letter(char_in);
  assign raw_upper = (char_in inside {[CHAR_UPPER_A:CHAR_UPPER_Z]});
  assign raw_idx   = raw_upper ? 5'(char_in - CHAR_UPPER_A) : LETTER_J;
  assign doubled   = previous_valid && (previous_letter == key_idx);

  // Classify the item and prepare text into pairs
  always_comb begin
    push                 = 1'b0;
    push_op              = '{kind: OP_CLEAR, a: '0, b: '0};
    pending_letter_next  = pending_letter;
    pending_valid_next   = pending_valid;
    previous_letter_next = previous_letter;
    previous_valid_next  = previous_valid;
    if (accept) begin
      case (command)
        CMD_KEY_START: begin
          push                 = 1'b1;
          pending_letter_next  = '0;
          pending_valid_next   = 1'b0;
          previous_letter_next = '0;
          previous_valid_next  = 1'b0;
        end
        CMD_KEY_LETTER: begin
          if (key_ok) begin
            push    = 1'b1;
            push_op = '{kind: OP_PLACE, a: key_idx, b: '0};
          end
        end
        CMD_KEY_FINISH: begin
          push    = 1'b1;
          push_op = '{kind: OP_FINISH, a: '0, b: '0};
        end
        CMD_TEXT_CHAR: begin
          if (direction) begin
            // Decrypt: pair raw characters
            if (pending_valid) begin
              push                = 1'b1;
              push_op             = '{kind: OP_PAIR, a: pending_letter, b: raw_idx};
              pending_letter_next = '0;
              pending_valid_next  = 1'b0;
            end else begin
              pending_letter_next = raw_idx;
              pending_valid_next  = 1'b1;
            end
          end else if (key_ok) begin
            // Encrypt: split a doubled letter with X
            if (doubled && pending_valid) begin
              push                = 1'b1;
              push_op             = '{kind: OP_PAIR, a: pending_letter, b: LETTER_X};
              pending_letter_next = key_idx;
              pending_valid_next  = 1'b1;
            end else if (doubled) begin
              push                = 1'b1;
              push_op             = '{kind: OP_PAIR, a: LETTER_X, b: key_idx};
              pending_letter_next = '0;
              pending_valid_next  = 1'b0;
            end else if (pending_valid) begin
              push                = 1'b1;
              push_op             = '{kind: OP_PAIR, a: pending_letter, b: key_idx};
              pending_letter_next = '0;
              pending_valid_next  = 1'b0;
            end else begin
              pending_letter_next = key_idx;
              pending_valid_next  = 1'b1;
            end
            previous_letter_next = key_idx;
            previous_valid_next  = 1'b1;
          end
        end
        CMD_TEXT_END: begin
          // Flush an open pair with the pad letter
          if (pending_valid) begin
            push    = 1'b1;
            push_op = '{kind: OP_PAIR, a: pending_letter,
                        b: (direction ? LETTER_J : LETTER_X)};
          end
          pending_letter_next  = '0;
          pending_valid_next   = 1'b0;
          previous_letter_next = '0;
          previous_valid_next  = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // Hold text preparation state
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_letter  <= '0;
      pending_valid   <= 1'b0;
      previous_letter <= '0;
      previous_valid  <= 1'b0;
    end else begin
      pending_letter  <= pending_letter_next;
      pending_valid   <= pending_valid_next;
      previous_letter <= previous_letter_next;
      previous_valid  <= previous_valid_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pfdc_back.sv =====
`default_nettype none

`include "playfair_digraph_cipher_macros.svh"

module pfdc_back (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       direction,
  input  wire logic       op_valid,
  input  pfdc_pkg::op_t   op,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [6:0]      letter_out,
  output logic            run_last
);
  import pfdc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FINISH,
    S_GRID,
    S_EMIT1,
    S_EMIT2
  } state_t;

  state_t               state;
  logic [LETTERS-1:0]   used;
  letter_t              fill_count;
  coord_t               fill_row;
  coord_t               fill_col;
  letter_t              walk;

  // Key grid and letter positions ({row, col})
  letter_t              grid [GRID_CELLS];
  logic [5:0]           pos  [LETTERS];

  logic [5:0]           pa, pb;
  letter_t              g1, g2;

  logic                 place_req;
  letter_t              place_idx;
  logic                 place_do;
  logic                 pair_pop;
  logic                 out_free;
  logic                 emit;
  logic                 walk_done;
  logic                 grid_full;
  coord_t               r1, c1, r2, c2;
  letter_t              cell1, cell2;

  function automatic coord_t step5(input coord_t v, input logic back);
    if (back) return (v == '0) ? coord_t'(GRID_SIDE - 1) : v - 3'd1;
    return (v == coord_t'(GRID_SIDE - 1)) ? '0 : v + 3'd1;
  endfunction

  function automatic letter_t cell_of(input coord_t r, input coord_t c);
    return {r, 2'b00} + 5'(r) + 5'(c);
  endfunction

  assign pop       = (state == S_IDLE) && op_valid;
  assign pair_pop  = pop && (op.kind == OP_PAIR);
  assign out_free  = !out_valid || out_ready;
  assign emit      = out_free && ((state == S_EMIT1) || (state == S_EMIT2));
  assign walk_done = (state == S_FINISH) && (walk == letter_t'(GRID_CELLS - 1));
  assign grid_full = (fill_count == letter_t'(GRID_CELLS));

  // Pick the letter to place from a key op or the finish walk
  always_comb begin
    place_req = 1'b0;
    place_idx = op.a;
    if (state == S_FINISH) begin
      place_req = 1'b1;
      place_idx = fill_letter(walk);
    end else if (pop && op.kind == OP_PLACE) begin
      place_req = 1'b1;
    end
  end

  assign place_do = place_req && !used[place_idx] &&
                    (fill_count < letter_t'(GRID_CELLS));

  // Apply the Playfair rule to the looked-up positions
  assign r1 = pa[5:3];
  assign c1 = pa[2:0];
  assign r2 = pb[5:3];
  assign c2 = pb[2:0];

  always_comb begin
    if (r1 == r2) begin
      cell1 = cell_of(r1, step5(c1, direction));
      cell2 = cell_of(r2, step5(c2, direction));
    end else if (c1 == c2) begin
      cell1 = cell_of(step5(r1, direction), c1);
      cell2 = cell_of(step5(r2, direction), c2);
    end else begin
      cell1 = cell_of(r1, c2);
      cell2 = cell_of(r2, c1);
    end
  end

  // Write the grid and positions; registered reads
  always_ff @(posedge clk) begin
    if (place_do) begin
      grid[fill_count] <= place_idx;
      pos[place_idx]   <= {fill_row, fill_col};
    end
    if (pair_pop) begin
      pa <= used[op.a] ? pos[op.a] : '0;
      pb <= used[op.b] ? pos[op.b] : '0;
    end
    if (state == S_GRID) begin
      g1 <= (cell1 < fill_count) ? grid[cell1] : '0;
      g2 <= (cell2 < fill_count) ? grid[cell2] : '0;
    end
  end

  // Sequence ops, track the key fill and drive the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      used       <= '0;
      fill_count <= '0;
      fill_row   <= '0;
      fill_col   <= '0;
      walk       <= '0;
      out_valid  <= 1'b0;
      letter_out <= '0;
      run_last   <= 1'b0;
    end else begin
      // Raise the item on an emit, drop it once taken
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      if (place_do) begin
        used[place_idx] <= 1'b1;
        fill_count      <= fill_count + 5'd1;
        if (fill_col == coord_t'(GRID_SIDE - 1)) begin
          fill_col <= '0;
          fill_row <= fill_row + 3'd1;
        end else begin
          fill_col <= fill_col + 3'd1;
        end
      end

      case (state)
        S_IDLE: begin
          if (pop) begin
            case (op.kind)
              OP_CLEAR: begin
                used       <= '0;
                fill_count <= '0;
                fill_row   <= '0;
                fill_col   <= '0;
              end
              OP_FINISH: begin
                walk  <= '0;
                state <= S_FINISH;
              end
              OP_PAIR: state <= S_GRID;
              default: begin
              end
            endcase
          end
        end
        S_FINISH: begin
          if (walk_done) state <= S_IDLE;
          else walk <= walk + 5'd1;
        end
        S_GRID: state <= S_EMIT1;
        S_EMIT1: begin
          if (out_free) begin
            letter_out <= 7'(g1) + OUT_BASE;
            run_last   <= 1'b0;
            state      <= S_EMIT2;
          end
        end
        S_EMIT2: begin
          if (out_free) begin
            letter_out <= 7'(g2) + OUT_BASE;
            run_last   <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PFDC_ASSERT(a_fill_bound, clk, rst, fill_count <= letter_t'(GRID_CELLS), "fill count past grid")
  `PFDC_ASSERT_NEXT(a_finish_full, clk, rst, walk_done, grid_full, "key finish left grid short")
  `PFDC_ASSERT(a_no_j_out, clk, rst, out_valid |-> (letter_out != (7'(LETTER_J) + OUT_BASE)), "J emitted from grid")

endmodule

`default_nettype wire

// ===== rtl/playfair_digraph_cipher.sv =====
`default_nettype none
// The queue registers each item; the pop registers the letter positions, S_GRID the grid
// letters, and S_EMIT1 and S_EMIT2 one output letter each, once the output is free.
// A pair holds the back-end sequencer through S_GRID, S_EMIT1 and S_EMIT2; a key op needs
// only the pop; key finish adds one grid-fill step per letter of the 25-letter set.
// Reset: rst clears the key grid (unwritten cells read as A), the text state, the queue
// and the direction register (encrypt).

module playfair_digraph_cipher (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] command,
  input  wire logic [7:0] char_in,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [6:0]      letter_out,
  output logic            run_last
);
  import pfdc_pkg::*;

  logic direction;
  logic q_full;
  logic q_empty;
  logic push;
  logic pop;
  op_t  push_op;
  op_t  head_op;

  assign cfg_ready = 1'b1;

  // Hold the direction register
  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      direction <= cfg_data;
    end
  end

  pfdc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .direction (direction),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .char_in   (char_in),
    .q_full    (q_full),
    .push      (push),
    .push_op   (push_op)
  );

  pfdc_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (pop),
    .head_op (head_op),
    .empty   (q_empty)
  );

  pfdc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .direction  (direction),
    .op_valid   (!q_empty),
    .op         (head_op),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .letter_out (letter_out),
    .run_last   (run_last)
  );

endmodule

`default_nettype wire

// ===== tb/sv/playfair_digraph_cipher_test.sv =====
`timescale 1ns / 100ps

module playfair_digraph_cipher_test;
  import pfdc_pkg::*;

  // Commands the block decodes as no-ops
  localparam logic [2:0] CMD_SPARE_5 = 3'd5;
  localparam logic [2:0] CMD_SPARE_6 = 3'd6;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;

  // Direction register values
  localparam bit DIR_ENCRYPT = 1'b0;
  localparam bit DIR_DECRYPT = 1'b1;

  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 3000;
  localparam int REPORT_LIMIT  = 10;

  typedef struct packed {
    logic [6:0] letter;
    logic       last;
  } cipher_letter_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] command = CMD_KEY_START;
  logic [7:0] char_in = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [6:0] letter_out;
  logic       run_last;

  // Predicted cipher state
  letter_t     key_grid [GRID_CELLS];
  logic [5:0]  key_pos [LETTERS];
  bit          key_used [LETTERS];
  int          key_fill;
  letter_t     open_letter;
  bit          open_valid;
  letter_t     last_text;
  bit          last_valid;
  bit          dir_decrypt;

  cipher_letter_t expected_letters [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request = 0;
  int hold_left = 0;
  int items_sent = 0;
  int mismatches = 0;
  int stall_cycles = 0;

  playfair_digraph_cipher DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .char_in    (char_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .letter_out (letter_out),
    .run_last   (run_last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_text_state();
    open_letter = '0;
    open_valid  = 1'b0;
    last_text   = '0;
    last_valid  = 1'b0;
  endfunction

  function automatic void clear_key_state();
    for (int i = 0; i < GRID_CELLS; i++) key_grid[i] = '0;
    for (int i = 0; i < LETTERS; i++) begin
      key_pos[i]  = '0;
      key_used[i] = 1'b0;
    end
    key_fill = 0;
  endfunction

  // Upper-case letter index with J folded to I, LETTERS for a non-letter
  function automatic int fold_to_index(input logic [7:0] ch);
    logic [7:0] c;
    int idx;
    c = ch;
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) c = c - CASE_OFFSET;
    if (c < CHAR_UPPER_A || c > CHAR_UPPER_Z) return LETTERS;
    idx = int'(c - CHAR_UPPER_A);
    return (idx == int'(LETTER_J)) ? int'(LETTER_I) : idx;
  endfunction

  function automatic void place_key_letter(input int idx);
    if (idx >= LETTERS || key_fill >= GRID_CELLS || key_used[idx]) return;
    key_used[idx] = 1'b1;
    key_grid[key_fill] = letter_t'(idx);
    key_pos[idx] = 6'(((key_fill / GRID_SIDE) << 3) | (key_fill % GRID_SIDE));
    key_fill++;
  endfunction

  function automatic void queue_grid_letter(input int row, input int col, input bit last);
    cipher_letter_t item;
    int grid_idx;
    grid_idx = (row % GRID_SIDE) * GRID_SIDE + (col % GRID_SIDE);
    item.letter = {2'b00, key_grid[grid_idx]} + OUT_BASE;
    item.last   = last;
    expected_letters.push_back(item);
  endfunction

  // Apply the digraph rules to one completed pair
  function automatic void cipher_pair(input int a, input int b);
    int r1, c1, r2, c2, shift;
    r1 = (key_pos[a % LETTERS] >> 3) % GRID_SIDE;
    c1 = (key_pos[a % LETTERS] & 7) % GRID_SIDE;
    r2 = (key_pos[b % LETTERS] >> 3) % GRID_SIDE;
    c2 = (key_pos[b % LETTERS] & 7) % GRID_SIDE;
    shift = dir_decrypt ? GRID_SIDE - 1 : 1;
    if (r1 == r2) begin
      queue_grid_letter(r1, c1 + shift, 1'b0);
      queue_grid_letter(r2, c2 + shift, 1'b1);
    end else if (c1 == c2) begin
      queue_grid_letter(r1 + shift, c1, 1'b0);
      queue_grid_letter(r2 + shift, c2, 1'b1);
    end else begin
      queue_grid_letter(r1, c2, 1'b0);
      queue_grid_letter(r2, c1, 1'b1);
    end
  endfunction

  function automatic void take_text_letter(input int idx);
    if (open_valid) begin
      cipher_pair(int'(open_letter), idx);
      open_valid  = 1'b0;
      open_letter = '0;
    end else begin
      open_letter = letter_t'(idx);
      open_valid  = 1'b1;
    end
  endfunction

  function automatic void predict_item(input logic [2:0] cmd, input logic [7:0] ch);
    int idx;
    case (cmd)
      CMD_KEY_START: begin
        clear_key_state();
        clear_text_state();
      end
      CMD_KEY_LETTER: place_key_letter(fold_to_index(ch));
      CMD_KEY_FINISH: begin
        for (int i = 0; i < LETTERS; i++)
          if (i != int'(LETTER_J)) place_key_letter(i);
      end
      CMD_TEXT_CHAR: begin
        if (dir_decrypt) begin
          // Raw pairing: anything but upper case lands on the unplaced J
          idx = (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) ? int'(ch - CHAR_UPPER_A)
                                                           : int'(LETTER_J);
          take_text_letter(idx);
        end else begin
          idx = fold_to_index(ch);
          if (idx < LETTERS) begin
            if (last_valid && int'(last_text) == idx) take_text_letter(int'(LETTER_X));
            take_text_letter(idx);
            last_text  = letter_t'(idx);
            last_valid = 1'b1;
          end
        end
      end
      CMD_TEXT_END: begin
        if (open_valid) take_text_letter(dir_decrypt ? int'(LETTER_J) : int'(LETTER_X));
        clear_text_state();
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one item, hold it until accepted, then update the prediction
  task automatic send_item(input logic [2:0] cmd, input logic [7:0] ch);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    char_in  <= ch;
    do @(posedge clk); while (!in_ready);
    predict_item(cmd, ch);
    items_sent++;
  endtask

  task automatic send_string(input logic [2:0] cmd, input string s);
    for (int i = 0; i < s.len(); i++) send_item(cmd, s[i]);
  endtask

  // Drain the block, then write the direction register
  task automatic write_direction(input bit dir);
    in_valid <= 1'b0;
    while (expected_letters.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= dir;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    dir_decrypt = dir;
  endtask

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each result with the oldest prediction
  always @(posedge clk) begin : check_letters
    cipher_letter_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_letters.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result: letter %c run_last %0b", letter_out, run_last);
      end else begin
        want = expected_letters.pop_front();
        if (letter_out !== want.letter || run_last !== want.last) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("mismatch: expected letter %c run_last %0b, got letter %c run_last %0b",
                     want.letter, want.last, letter_out, run_last);
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  initial begin
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Text before any key: every grid position reads as A
  task automatic test_unkeyed_text();
    send_string(CMD_TEXT_CHAR, "AB");
    send_item(CMD_TEXT_END, 8'd0);
  endtask

  // Key load with case folding, J as I, repeats, non-letters and a full grid
  task automatic test_key_load();
    send_item(CMD_KEY_START, 8'd0);
    send_string(CMD_KEY_LETTER, "pLaJyi!");
    send_item(CMD_KEY_LETTER, 8'hFF);
    send_item(CMD_KEY_FINISH, 8'd0);
    send_item(CMD_KEY_FINISH, 8'd0);
    send_item(CMD_KEY_LETTER, "W");
  endtask

  // Encrypt preparation: doubled letters, J, case, non-letters, odd end
  task automatic test_encrypt_prep();
    send_string(CMD_TEXT_CHAR, "eeJ z");
    send_item(CMD_TEXT_CHAR, 8'h00);
    send_item(CMD_TEXT_END, 8'd0);
    send_item(CMD_TEXT_END, 8'd0);
    send_item(CMD_SPARE_5, 8'hFF);
    send_item(CMD_SPARE_6, "A");
    send_item(CMD_SPARE_7, "B");
  endtask

  // Decrypt raw pairs: lower case and symbols have no grid place
  task automatic test_decrypt_raw();
    write_direction(DIR_DECRYPT);
    send_string(CMD_TEXT_CHAR, "Qj~");
    send_item(CMD_TEXT_END, 8'd0);
  endtask

  // Open pair carried across a direction change
  task automatic test_direction_switch();
    write_direction(DIR_ENCRYPT);
    send_item(CMD_TEXT_CHAR, "K");
    write_direction(DIR_DECRYPT);
    send_item(CMD_TEXT_CHAR, "M");
    send_item(CMD_TEXT_END, 8'd0);
  endtask

  function automatic logic [7:0] random_letter();
    logic [7:0] ch;
    ch = CHAR_UPPER_A + 8'($urandom_range(25));
    if ($urandom_range(1) != 0) ch = ch + CASE_OFFSET;
    return ch;
  endfunction

  // One message: optional new key, then a text run, usually closed
  task automatic send_random_session();
    int key_len;
    int text_len;
    logic [7:0] ch;
    logic [7:0] prev_ch;
    if ($urandom_range(99) < 85) begin
      send_item(CMD_KEY_START, 8'($urandom));
      key_len = $urandom_range(12);
      for (int i = 0; i < key_len; i++)
        send_item(CMD_KEY_LETTER, ($urandom_range(99) < 75) ? random_letter() : 8'($urandom));
      if ($urandom_range(99) < 90) send_item(CMD_KEY_FINISH, 8'($urandom));
    end
    text_len = $urandom_range(1, 16);
    prev_ch = random_letter();
    for (int i = 0; i < text_len; i++) begin
      case ($urandom_range(9))
        0:       ch = 8'($urandom);
        1, 2:    ch = prev_ch;
        3:       ch = CHAR_UPPER_A + 8'($urandom_range(25));
        default: ch = random_letter();
      endcase
      if (dir_decrypt && $urandom_range(3) != 0 && ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z)
        ch = ch - CASE_OFFSET;
      send_item(CMD_TEXT_CHAR, ch);
      prev_ch = ch;
    end
    if ($urandom_range(99) < 85) send_item(CMD_TEXT_END, 8'($urandom));
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int count);
    int goal;
    int noise;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    goal = items_sent + count;
    while (items_sent < goal) begin
      if ($urandom_range(99) < 20) write_direction(1'($urandom_range(1)));
      if ($urandom_range(99) < 20) begin
        noise = $urandom_range(1, 3);
        for (int i = 0; i < noise; i++)
          send_item(3'($urandom_range(7)), 8'($urandom));
      end
      send_random_session();
    end
  endtask

  // Receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_direction(DIR_ENCRYPT);
    send_item(CMD_KEY_START, 8'd0);
    send_string(CMD_KEY_LETTER, "monarchy");
    send_item(CMD_KEY_FINISH, 8'd0);
    hold_request = HOLD_CYCLES;
    send_string(CMD_TEXT_CHAR, "instrumentsplacedhereforbackup");
    send_item(CMD_TEXT_END, 8'd0);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    clear_key_state();
    clear_text_state();
    dir_decrypt = DIR_ENCRYPT;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_unkeyed_text();
    test_key_load();
    test_encrypt_prep();
    test_decrypt_raw();
    test_direction_switch();
    test_random_traffic(12, 81, 350);
    test_random_traffic(81, 12, 350);
    test_backpressure();
    test_random_traffic(0, 0, 350);

    // Drain, then allow for stray results
    in_valid <= 1'b0;
    while (expected_letters.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_letters.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
